[design/assert_macros.svh]
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[design/bmlc_pkg.sv]
// Shared types and constants of the button mode and level controller.
package bmlc_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned VAL_W  = 8;

	// Register reset values
	localparam logic [VAL_W-1:0] SHORT_TICKS_RST    = 8'd8;
	localparam logic [VAL_W-1:0] LONG_TICKS_RST     = 8'd200;
	localparam logic [VAL_W-1:0] BLINK_TICKS_RST    = 8'd100;
	localparam logic [VAL_W-1:0] BLINK_ON_ABOVE_RST = 8'd50;
	localparam logic [VAL_W-1:0] DUTY_LOW_RST       = 8'd100;
	localparam logic [VAL_W-1:0] DUTY_MID_RST       = 8'd112;
	localparam logic [VAL_W-1:0] DUTY_HIGH_RST      = 8'd124;

	// Register indexes (word address)
	typedef enum logic [2:0] {
		REG_SHORT_TICKS    = 3'd0,
		REG_LONG_TICKS     = 3'd1,
		REG_BLINK_TICKS    = 3'd2,
		REG_BLINK_ON_ABOVE = 3'd3,
		REG_DUTY_LOW       = 3'd4,
		REG_DUTY_MID       = 3'd5,
		REG_DUTY_HIGH      = 3'd6
	} reg_idx_t;

	// Mode codes
	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_LOW  = 2'd1;
	localparam logic [1:0] MODE_MID  = 2'd2;
	localparam logic [1:0] MODE_HIGH = 2'd3;

	// LED patterns
	localparam logic [2:0] LED_NONE = 3'b000;
	localparam logic [2:0] LED_1    = 3'b001;
	localparam logic [2:0] LED_2    = 3'b010;
	localparam logic [2:0] LED_3    = 3'b100;
	localparam logic [2:0] LED_ALL  = 3'b111;

	localparam logic [VAL_W-1:0] HOLD_MAX = 8'hFF;

	typedef struct packed {
		logic [VAL_W-1:0] short_ticks;
		logic [VAL_W-1:0] long_ticks;
		logic [VAL_W-1:0] blink_ticks;
		logic [VAL_W-1:0] blink_on_above;
		logic [VAL_W-1:0] duty_low;
		logic [VAL_W-1:0] duty_mid;
		logic [VAL_W-1:0] duty_high;
	} cfg_t;

	typedef struct packed {
		logic             pwm_enable;
		logic [VAL_W-1:0] duty;
		logic [2:0]       leds;
		logic             sleep_request;
		logic [1:0]       mode;
	} res_t;

endpackage

[design/button_mode_level_controller_unit.sv]
// Top level of the button mode and level controller.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   key_pressed, work_select
//   out      source     out_valid / out_ready pwm_enable, duty, led1..3_on, sleep_request, mode
//   cfg      APB slave  psel/penable/pready   paddr, pwdata, prdata
//
// One tick per cycle unless the result register stalls: a beat lands in the input register,
// and as it moves on, the key/mode/blink logic runs and writes the state and the result
// register together.
// Reset clears the state and loads the register defaults; no sweep is needed.
// A stalled result register holds the input stage, which then holds in_ready low.
`include "assert_macros.svh"

module button_mode_level_controller_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bmlc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bmlc_pkg::DATA_W-1:0]   pwdata,
	output logic [bmlc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          key_pressed,
	input  logic                          work_select,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          pwm_enable,
	output logic [bmlc_pkg::VAL_W-1:0]    duty,
	output logic                          led1_on,
	output logic                          led2_on,
	output logic                          led3_on,
	output logic                          sleep_request,
	output logic [1:0]                    mode
);

	bmlc_pkg::cfg_t cfg;
	bmlc_pkg::res_t res;
	bmlc_pkg::res_t res_s2;
	logic           valid_s1;
	logic           key_s1;
	logic           work_s1;
	logic           valid_s2;
	logic           adv;

	assign pready = 1'b1;

	bmlc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Move a tick out of the input stage when the result register is free
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1  <= key_pressed;
			work_s1 <= work_select;
		end
	end

	bmlc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.key_pressed (key_s1),
		.work_select (work_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign pwm_enable    = res_s2.pwm_enable;
	assign duty          = res_s2.duty;
	assign led1_on       = res_s2.leds[0];
	assign led2_on       = res_s2.leds[1];
	assign led3_on       = res_s2.leds[2];
	assign sleep_request = res_s2.sleep_request;
	assign mode          = res_s2.mode;

	// A sleep request leaves the mode off and every LED dark
	`ASSERT_SAME(a_sleep_dark, out_valid && sleep_request, (mode == bmlc_pkg::MODE_OFF) && !pwm_enable && !led1_on && !led2_on && !led3_on)
	// PWM runs exactly when a level is selected
	`ASSERT_SAME(a_pwm_mode, out_valid, pwm_enable == (mode != bmlc_pkg::MODE_OFF))
	// LEDs show one level, all on, or none
	`ASSERT_SAME(a_led_pattern, out_valid, $onehot0({led3_on, led2_on, led1_on}) || (led1_on && led2_on && led3_on))
	// An accepted beat is in the input stage next cycle
	`ASSERT_NEXT(a_in_taken, in_valid && in_ready, valid_s1)

endmodule

[design/bmlc_cfg_regs.sv]
// APB register file holding the controller thresholds and duty levels.
module bmlc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bmlc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bmlc_pkg::DATA_W-1:0]   pwdata,
	output logic [bmlc_pkg::DATA_W-1:0]   prdata,
	output bmlc_pkg::cfg_t                cfg
);

	bmlc_pkg::cfg_t             cfg_q;
	bmlc_pkg::reg_idx_t         idx;
	logic                       wr_en;
	logic [bmlc_pkg::VAL_W-1:0] wval;
	logic [bmlc_pkg::VAL_W-1:0] rval;

	assign idx   = bmlc_pkg::reg_idx_t'(paddr[bmlc_pkg::ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign wval  = pwdata[bmlc_pkg::VAL_W-1:0];

	// Write the addressed register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_ticks    <= bmlc_pkg::SHORT_TICKS_RST;
			cfg_q.long_ticks     <= bmlc_pkg::LONG_TICKS_RST;
			cfg_q.blink_ticks    <= bmlc_pkg::BLINK_TICKS_RST;
			cfg_q.blink_on_above <= bmlc_pkg::BLINK_ON_ABOVE_RST;
			cfg_q.duty_low       <= bmlc_pkg::DUTY_LOW_RST;
			cfg_q.duty_mid       <= bmlc_pkg::DUTY_MID_RST;
			cfg_q.duty_high      <= bmlc_pkg::DUTY_HIGH_RST;
		end else if (wr_en) begin
			unique case (idx)
				bmlc_pkg::REG_SHORT_TICKS:    cfg_q.short_ticks    <= wval;
				bmlc_pkg::REG_LONG_TICKS:     cfg_q.long_ticks     <= wval;
				bmlc_pkg::REG_BLINK_TICKS:    cfg_q.blink_ticks    <= wval;
				bmlc_pkg::REG_BLINK_ON_ABOVE: cfg_q.blink_on_above <= wval;
				bmlc_pkg::REG_DUTY_LOW:       cfg_q.duty_low       <= wval;
				bmlc_pkg::REG_DUTY_MID:       cfg_q.duty_mid       <= wval;
				bmlc_pkg::REG_DUTY_HIGH:      cfg_q.duty_high      <= wval;
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			bmlc_pkg::REG_SHORT_TICKS:    rval = cfg_q.short_ticks;
			bmlc_pkg::REG_LONG_TICKS:     rval = cfg_q.long_ticks;
			bmlc_pkg::REG_BLINK_TICKS:    rval = cfg_q.blink_ticks;
			bmlc_pkg::REG_BLINK_ON_ABOVE: rval = cfg_q.blink_on_above;
			bmlc_pkg::REG_DUTY_LOW:       rval = cfg_q.duty_low;
			bmlc_pkg::REG_DUTY_MID:       rval = cfg_q.duty_mid;
			bmlc_pkg::REG_DUTY_HIGH:      rval = cfg_q.duty_high;
			default:                      rval = '0;
		endcase
	end

	assign prdata = {{(bmlc_pkg::DATA_W-bmlc_pkg::VAL_W){1'b0}}, rval};
	assign cfg    = cfg_q;

endmodule

[design/bmlc_core.sv]
// Per-tick key, mode, duty and blink logic with its state registers.
module bmlc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           key_pressed,
	input  logic           work_select,
	input  bmlc_pkg::cfg_t cfg,
	output bmlc_pkg::res_t res
);

	logic [1:0]                 mode_q;
	logic [bmlc_pkg::VAL_W-1:0] hold_q;
	logic                       latch_q;
	logic [bmlc_pkg::VAL_W-1:0] blink_q;
	logic [bmlc_pkg::VAL_W-1:0] duty_q;
	logic [2:0]                 led_q;

	logic [1:0]                 mode_d;
	logic [bmlc_pkg::VAL_W-1:0] hold_d;
	logic                       latch_d;
	logic [bmlc_pkg::VAL_W-1:0] blink_d;
	logic [bmlc_pkg::VAL_W-1:0] duty_d;
	logic [2:0]                 led_d;
	logic                       sleep_d;

	// Next state for one tick
	always_comb begin
		logic [bmlc_pkg::VAL_W-1:0] hold_inc;
		logic                       ev_short;
		logic                       ev_long;

		mode_d   = mode_q;
		hold_d   = hold_q;
		latch_d  = latch_q;
		blink_d  = blink_q;
		duty_d   = duty_q;
		led_d    = led_q;
		sleep_d  = 1'b0;
		ev_short = 1'b0;
		ev_long  = 1'b0;
		hold_inc = (hold_q == bmlc_pkg::HOLD_MAX) ? hold_q : hold_q + 8'd1;

		// Key: count held ticks, report long press once, short press on release
		if (key_pressed) begin
			hold_d = hold_inc;
			if (hold_inc >= cfg.long_ticks) begin
				hold_d = cfg.long_ticks;
				if (!latch_q) begin
					latch_d = 1'b1;
					ev_long = 1'b1;
				end
			end
		end else begin
			hold_d = '0;
			if (hold_q >= cfg.long_ticks)
				latch_d = 1'b0;
			else if (hold_q >= cfg.short_ticks)
				ev_short = 1'b1;
		end

		// Mode step
		if (ev_short) begin
			if (mode_q == bmlc_pkg::MODE_OFF)
				blink_d = cfg.blink_ticks;
			mode_d = (mode_q == bmlc_pkg::MODE_HIGH) ? bmlc_pkg::MODE_LOW : mode_q + 2'd1;
		end else if (ev_long) begin
			mode_d  = bmlc_pkg::MODE_OFF;
			blink_d = cfg.blink_ticks;
		end

		// Work: duty and level LED; charge: keep the blink going
		if (work_select) begin
			case (mode_d)
				bmlc_pkg::MODE_OFF: begin
					duty_d = cfg.duty_low;
					if (hold_d == '0 && blink_d == '0) begin
						led_d   = bmlc_pkg::LED_NONE;
						sleep_d = 1'b1;
					end
				end
				bmlc_pkg::MODE_LOW: begin
					duty_d = cfg.duty_low;
					if (blink_d == '0) led_d = bmlc_pkg::LED_1;
				end
				bmlc_pkg::MODE_MID: begin
					duty_d = cfg.duty_mid;
					if (blink_d == '0) led_d = bmlc_pkg::LED_2;
				end
				default: begin
					duty_d = cfg.duty_high;
					if (blink_d == '0) led_d = bmlc_pkg::LED_3;
				end
			endcase
		end else if (blink_d == '0) begin
			blink_d = cfg.blink_ticks;
		end

		// Blink countdown drives all LEDs
		if (blink_d != '0) begin
			blink_d = blink_d - 8'd1;
			led_d   = (blink_d > cfg.blink_on_above) ? bmlc_pkg::LED_ALL : bmlc_pkg::LED_NONE;
		end
	end

	// Advance state on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bmlc_pkg::MODE_OFF;
			hold_q  <= '0;
			latch_q <= 1'b0;
			blink_q <= '0;
			duty_q  <= bmlc_pkg::DUTY_LOW_RST;
			led_q   <= bmlc_pkg::LED_ALL;
		end else if (step) begin
			mode_q  <= mode_d;
			hold_q  <= hold_d;
			latch_q <= latch_d;
			blink_q <= blink_d;
			duty_q  <= duty_d;
			led_q   <= led_d;
		end
	end

	assign res.pwm_enable    = (mode_d != bmlc_pkg::MODE_OFF);
	assign res.duty          = duty_d;
	assign res.leds          = led_d;
	assign res.sleep_request = sleep_d;
	assign res.mode          = mode_d;

endmodule

[tb/sv/bmlc_checker.sv]
`timescale 1ns / 1ps
// Checker for the button mode and level controller: predicts each tick and compares results.
module bmlc_checker
	import bmlc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                key_pressed,
	input  logic                work_select,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                pwm_enable,
	input  logic [VAL_W-1:0]    duty,
	input  logic                led1_on,
	input  logic                led2_on,
	input  logic                led3_on,
	input  logic                sleep_request,
	input  logic [1:0]          mode,
	output int unsigned         pending,
	output int unsigned         fail_count
);

	localparam int unsigned PRINT_CAP = 100;

	typedef enum logic [1:0] {
		KEY_NONE,
		KEY_SHORT,
		KEY_LONG
	} key_evt_t;

	// Shadow of the register file and of the controller state
	cfg_t             cfg;
	logic [1:0]       mode_now;
	logic [VAL_W-1:0] hold_ticks;
	logic             long_seen;
	logic [VAL_W-1:0] blink_left;
	logic [VAL_W-1:0] duty_now;
	logic [2:0]       led_now;

	res_t tick_out_q[$];
	res_t want;
	res_t nxt;

	int unsigned miss_count = 0;

	assign fail_count = miss_count;

	task automatic flag_mismatch(input string what, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (miss_count < PRINT_CAP)
			$display("%0t: %s predicted %0d, got %0d", $time, what, want_v, got_v);
		miss_count++;
	endtask

	// Run one tick of key, mode and blink logic on the shadow state
	task automatic advance_controller(input logic key, input logic work, output res_t r);
		key_evt_t evt;
		logic     asleep;
		evt = KEY_NONE;
		asleep = 1'b0;

		// Key: count held ticks, report short press on release, long press once
		if (key) begin
			if (hold_ticks != HOLD_MAX)
				hold_ticks = hold_ticks + 8'd1;
			if (hold_ticks >= cfg.long_ticks) begin
				hold_ticks = cfg.long_ticks;
				if (!long_seen) begin
					long_seen = 1'b1;
					evt = KEY_LONG;
				end
			end
		end else if (hold_ticks >= cfg.long_ticks) begin
			hold_ticks = '0;
			long_seen = 1'b0;
		end else begin
			if (hold_ticks >= cfg.short_ticks)
				evt = KEY_SHORT;
			hold_ticks = '0;
		end

		// Mode stepping
		case (evt)
			KEY_SHORT: begin
				if (mode_now == MODE_OFF)
					blink_left = cfg.blink_ticks;
				mode_now = (mode_now == MODE_HIGH) ? MODE_LOW : mode_now + 2'd1;
			end
			KEY_LONG: begin
				mode_now = MODE_OFF;
				blink_left = cfg.blink_ticks;
			end
			default: ;
		endcase

		// Work mode sets duty and indicator; charge mode keeps the blink going
		if (work) begin
			case (mode_now)
				MODE_OFF: begin
					duty_now = cfg.duty_low;
					if (hold_ticks == 0 && blink_left == 0) begin
						led_now = LED_NONE;
						asleep = 1'b1;
					end
				end
				MODE_LOW: begin
					duty_now = cfg.duty_low;
					if (blink_left == 0)
						led_now = LED_1;
				end
				MODE_MID: begin
					duty_now = cfg.duty_mid;
					if (blink_left == 0)
						led_now = LED_2;
				end
				default: begin
					duty_now = cfg.duty_high;
					if (blink_left == 0)
						led_now = LED_3;
				end
			endcase
		end else if (blink_left == 0) begin
			blink_left = cfg.blink_ticks;
		end

		// Blink countdown: all on above blink_on_above, all off at or below it
		if (blink_left != 0) begin
			blink_left = blink_left - 8'd1;
			led_now = (blink_left > cfg.blink_on_above) ? LED_ALL : LED_NONE;
		end

		r.pwm_enable    = (mode_now != MODE_OFF);
		r.duty          = duty_now;
		r.leds          = led_now;
		r.sleep_request = asleep;
		r.mode          = mode_now;
	endtask

	// Watch register writes, result beats and input beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.short_ticks    = SHORT_TICKS_RST;
			cfg.long_ticks     = LONG_TICKS_RST;
			cfg.blink_ticks    = BLINK_TICKS_RST;
			cfg.blink_on_above = BLINK_ON_ABOVE_RST;
			cfg.duty_low       = DUTY_LOW_RST;
			cfg.duty_mid       = DUTY_MID_RST;
			cfg.duty_high      = DUTY_HIGH_RST;
			mode_now   = MODE_OFF;
			hold_ticks = '0;
			long_seen  = 1'b0;
			blink_left = '0;
			duty_now   = DUTY_LOW_RST;
			led_now    = LED_ALL;
			tick_out_q.delete();
			pending <= 0;
		end else begin
			// Register write
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_SHORT_TICKS:    cfg.short_ticks    = pwdata[VAL_W-1:0];
					REG_LONG_TICKS:     cfg.long_ticks     = pwdata[VAL_W-1:0];
					REG_BLINK_TICKS:    cfg.blink_ticks    = pwdata[VAL_W-1:0];
					REG_BLINK_ON_ABOVE: cfg.blink_on_above = pwdata[VAL_W-1:0];
					REG_DUTY_LOW:       cfg.duty_low       = pwdata[VAL_W-1:0];
					REG_DUTY_MID:       cfg.duty_mid       = pwdata[VAL_W-1:0];
					REG_DUTY_HIGH:      cfg.duty_high      = pwdata[VAL_W-1:0];
					default: ;
				endcase
			end

			// Result beat: compare against the oldest prediction
			if (out_valid && out_ready) begin
				if (tick_out_q.size() == 0) begin
					flag_mismatch("result beat with no tick pending", 8'd0, 8'd1);
				end else begin
					want = tick_out_q.pop_front();
					if (pwm_enable !== want.pwm_enable)
						flag_mismatch("pwm_enable", want.pwm_enable, pwm_enable);
					if (duty !== want.duty)
						flag_mismatch("duty", want.duty, duty);
					if (led1_on !== want.leds[0])
						flag_mismatch("led1_on", want.leds[0], led1_on);
					if (led2_on !== want.leds[1])
						flag_mismatch("led2_on", want.leds[1], led2_on);
					if (led3_on !== want.leds[2])
						flag_mismatch("led3_on", want.leds[2], led3_on);
					if (sleep_request !== want.sleep_request)
						flag_mismatch("sleep_request", want.sleep_request, sleep_request);
					if (mode !== want.mode)
						flag_mismatch("mode", want.mode, mode);
				end
			end

			// Input beat: advance the shadow controller
			if (in_valid && in_ready) begin
				advance_controller(key_pressed, work_select, nxt);
				tick_out_q.push_back(nxt);
			end

			pending <= tick_out_q.size();
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, tick and register stimulus, and the final verdict.
module tb;
	import bmlc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DIRECTED_N  = 26;

	// Directed ticks as {key_pressed, work_select}, run with short 2, long 4, blink 3
	localparam logic [1:0] DIRECTED [DIRECTED_N] = '{
		2'b01,                          // idle in mode off: sleep
		2'b11, 2'b01,                   // release below short threshold
		2'b11, 2'b11, 2'b01,            // short press from off: mode 1, blink
		2'b01, 2'b01,                   // let the blink run down
		2'b11, 2'b11, 2'b01,            // mode 2
		2'b11, 2'b11, 2'b01,            // mode 3
		2'b11, 2'b11, 2'b01,            // wrap to mode 1
		2'b11, 2'b11, 2'b11, 2'b11, 2'b11, // long press, then held while latched
		2'b01,                          // release after long press
		2'b00, 2'b00,                   // charge indication
		2'b01
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               key_pressed;
	logic               work_select;
	logic               out_valid;
	logic               out_ready;
	logic               pwm_enable;
	logic [VAL_W-1:0]   duty;
	logic               led1_on;
	logic               led2_on;
	logic               led3_on;
	logic               sleep_request;
	logic [1:0]         mode;
	int unsigned        pending;
	int unsigned        fail_count;

	int unsigned cycle_count = 0;
	int unsigned sent;
	int          send_idle_pct;
	int          stall_pct;
	bit          holdoff_req;
	int          short_now;
	int          long_now;
	int          blink_now;

	button_mode_level_controller_unit dut (.*);
	bmlc_checker checker_i (.*);

	always #4 clk = ~clk;

	// Watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one tick, with random idle cycles ahead of it
	task automatic send_tick(input logic key, input logic work);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		key_pressed <= key;
		work_select <= work;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Drop valid and wait until every tick has produced its result
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(val & 8'hFF);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_config(input int s, input int l, input int b, input int o,
			input int dl, input int dm, input int dh);
		drain();
		write_reg(REG_SHORT_TICKS, s);
		write_reg(REG_LONG_TICKS, l);
		write_reg(REG_BLINK_TICKS, b);
		write_reg(REG_BLINK_ON_ABOVE, o);
		write_reg(REG_DUTY_LOW, dl);
		write_reg(REG_DUTY_MID, dm);
		write_reg(REG_DUTY_HIGH, dh);
		short_now = s;
		long_now  = l;
		blink_now = b;
	endtask

	// One press: hold for a length around the thresholds, then release
	task automatic play_press();
		int   held;
		int   rest;
		logic work;
		work = ($urandom_range(99) < 85);
		// Occasional noise burst
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(10, 1))
				send_tick($urandom_range(1), $urandom_range(1));
			return;
		end
		case ($urandom_range(3))
			0: held = (short_now > 1) ? $urandom_range(short_now - 1, 1) : 1;
			1: held = (long_now > short_now) ? $urandom_range(long_now - 1, short_now)
				: short_now;
			default: held = $urandom_range(long_now + 8, long_now);
		endcase
		rest = ($urandom_range(4) == 0) ? blink_now + 2 : $urandom_range(6, 1);
		if (rest > 60)
			rest = 60;
		repeat (held)
			send_tick(1'b1, ($urandom_range(19) == 0) ? ~work : work);
		repeat (rest)
			send_tick(1'b0, ($urandom_range(19) == 0) ? ~work : work);
	endtask

	task automatic run_phase(input int unsigned n, input int idle_v, input int stall_v,
			input bit held_tail);
		int unsigned stop_at;
		send_idle_pct = idle_v;
		stall_pct     = stall_v;
		stop_at       = sent + n;
		while (sent < stop_at)
			play_press();
		// Leave the key held so the next register write lands mid-press
		if (held_tail)
			repeat (3) send_tick(1'b1, 1'b1);
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int quiet;
		bit holdoff_done;
		quiet = 0;
		holdoff_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holdoff_req && !holdoff_done) begin
				holdoff_done = 1'b1;
				quiet = 100;
			end
			if (quiet > 0) begin
				out_ready <= 1'b0;
				quiet--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Main stimulus
	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		key_pressed   = 1'b0;
		work_select   = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		holdoff_req   = 1'b0;
		sent          = 0;
		short_now     = SHORT_TICKS_RST;
		long_now      = LONG_TICKS_RST;
		blink_now     = BLINK_TICKS_RST;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed walk through every mode and key case
		load_config(2, 4, 3, 1, 0, 255, 170);
		foreach (DIRECTED[i])
			send_tick(DIRECTED[i][1], DIRECTED[i][0]);

		// Reset values, no idling
		load_config(SHORT_TICKS_RST, LONG_TICKS_RST, BLINK_TICKS_RST, BLINK_ON_ABOVE_RST,
			DUTY_LOW_RST, DUTY_MID_RST, DUTY_HIGH_RST);
		run_phase(250, 0, 0, 1'b0);

		// Short, long and blink ticks at the top of their range: hold counter saturates
		load_config(255, 255, 255, 0, 255, 0, 255);
		run_phase(300, 0, 56, 1'b1);

		// Short, long and blink ticks at the bottom of their range: every press is long at once
		load_config(1, 1, 1, 255, 0, 255, 0);
		run_phase(150, 25, 25, 1'b0);

		// Short threshold above long; receiver holds off so the input stalls
		load_config(10, 5, 20, 10, 85, 170, 51);
		holdoff_req = 1'b1;
		run_phase(150, 0, 0, 1'b1);

		// Random small settings, cycling through the idle patterns
		for (int k = 0; k < 6; k++) begin
			int b;
			b = $urandom_range(40, 1);
			load_config($urandom_range(6, 1), $urandom_range(24, 1), b, $urandom_range(b, 0),
				$urandom_range(255), $urandom_range(255), $urandom_range(255));
			case (k % 4)
				0: run_phase(110, 56, 0, k[0]);
				1: run_phase(110, 0, 56, k[0]);
				2: run_phase(110, 25, 25, k[0]);
				default: run_phase(110, 0, 0, k[0]);
			endcase
		end

		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/bmlc_pkg.sv
design/bmlc_cfg_regs.sv
design/bmlc_core.sv
design/button_mode_level_controller_unit.sv
tb/sv/bmlc_checker.sv
tb/sv/tb.sv
